// ===== sv/assert_macros.svh =====
// Assertion macros for the checker file of the level meter.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define LVM_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("level meter check failed");

// Check a property on every clock edge, reset included.
`define LVM_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("level meter check failed");

`endif

// ===== sv/lvm_pkg.sv =====
// Shared constants, register codes and controller/datapath structs of the level meter.
// No dependencies.
`timescale 1ns / 1ps

package lvm_pkg;

    localparam int MAX_CHANNELS = 32;
    localparam int MAX_CHUNK    = 4096;
    localparam int SAMPLE_BITS  = 16;

    localparam int CH_W    = $clog2(MAX_CHANNELS);
    localparam int NCH_W   = 6;
    localparam int FR_W    = $clog2(MAX_CHUNK);
    localparam int NFR_W   = 13;
    localparam int COEF_W  = 16;
    localparam int LEVEL_W = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    localparam int SQ_W    = 2 * SAMPLE_BITS - 1;
    localparam int ACC_W   = SQ_W + FR_W;
    localparam int ROOT_W  = (ACC_W + 1) / 2;
    localparam int RAD_W   = 2 * ROOT_W;
    localparam int REM_W   = ROOT_W + 3;
    localparam int STEP_W  = $clog2(ROOT_W);
    localparam int FRESH_W = ROOT_W + COEF_W;
    localparam int DECAY_W = LEVEL_W + COEF_W;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_CHANS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_FRAMES     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_RECIPROCAL = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_COEFF      = 2'd3;

    localparam logic [NCH_W-1:0]  RST_ACTIVE_CHANS     = 6'd1;
    localparam logic [NFR_W-1:0]  RST_CHUNK_FRAMES     = 13'd256;
    localparam logic [COEF_W-1:0] RST_CHUNK_RECIPROCAL = 16'd256;
    localparam logic [COEF_W-1:0] RST_DECAY_COEFF      = 16'd58904;

    typedef struct packed {
        logic            acc_rd;
        logic            acc_wr;
        logic            burst_rd;
        logic            root_go;
        logic            mul;
        logic            emit;
        logic            last;
        logic            clear_all;
        logic [CH_W-1:0] addr;
    } t_cmd;

    typedef struct packed {
        logic root_busy;
        logic out_free;
    } t_stat;

endpackage

// ===== sv/lvm_in_if.sv =====
// Sample channel: valid/ready handshake carrying one signed sample per beat.
// Depends on lvm_pkg.
`timescale 1ns / 1ps

interface lvm_in_if import lvm_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

// ===== sv/lvm_out_if.sv =====
// Level channel: valid/ready handshake carrying one channel level per beat.
// Depends on lvm_pkg.
`timescale 1ns / 1ps

interface lvm_out_if import lvm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CH_W-1:0]    channel;
    logic [LEVEL_W-1:0] level;
    logic               last;

    modport source (output valid, output channel, output level, output last, input ready);
    modport sink   (input valid, input channel, input level, input last, output ready);
endinterface

// ===== sv/lvm_isqrt.sv =====
// Iterative integer square root, one result bit per cycle.
// Depends on lvm_pkg.
`timescale 1ns / 1ps

module lvm_isqrt import lvm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [RAD_W-1:0]  i_radicand,
    output logic              o_busy,
    output logic [ROOT_W-1:0] o_root
);

    logic [RAD_W-1:0]  r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [STEP_W-1:0] r_cnt;
    logic              r_busy;

    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              fits;

    always_comb begin
        rem_sh = {r_rem[REM_W-3:0], r_rad[RAD_W-1 -: 2]};
        trial  = {{(REM_W-ROOT_W-2){1'b0}}, r_root, 2'b01};
        fits   = (rem_sh >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && (r_cnt == '0)) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= STEP_W'(ROOT_W - 1);
        end else if (r_busy) begin
            r_rad <= r_rad << 2;
            r_cnt <= r_cnt - 1'b1;
            if (fits) begin
                r_rem  <= rem_sh - trial;
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root;

endmodule

// ===== sv/lvm_dp.sv =====
// Datapath: energy memory, level store, square root, scaling and the result register.
// Depends on lvm_pkg, lvm_out_if and lvm_isqrt.
`timescale 1ns / 1ps

module lvm_dp import lvm_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cmd                          i_cmd,
    output t_stat                         o_stat,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic [COEF_W-1:0]             i_recip,
    input  logic [COEF_W-1:0]             i_decay,
    lvm_out_if.source                     o_res
);

    logic [ACC_W-1:0]        r_mem [MAX_CHANNELS];
    logic [MAX_CHANNELS-1:0] r_vld;
    logic [ACC_W-1:0]        r_rd;
    logic                    r_rd_vld;
    logic [SQ_W-1:0]         r_sq;
    logic [LEVEL_W-1:0]      r_level [MAX_CHANNELS];
    logic [FRESH_W-1:0]      r_fresh;
    logic [DECAY_W-1:0]      r_decayed;

    logic                    r_ovalid;
    logic [CH_W-1:0]         r_ochan;
    logic [LEVEL_W-1:0]      r_olevel;
    logic                    r_olast;

    logic [SAMPLE_BITS-1:0]   mag;
    logic [2*SAMPLE_BITS-1:0] sq_full;
    logic [ACC_W-1:0]         acc_old;
    logic [ACC_W-1:0]         acc_new;
    logic                     root_busy;
    logic [ROOT_W-1:0]        root;
    logic [ROOT_W-1:0]        fresh_q;
    logic [ROOT_W-1:0]        decay_q;
    logic [ROOT_W-1:0]        pick;
    logic [LEVEL_W-1:0]       level_new;
    logic                     out_free;

    always_comb begin
        mag       = i_sample[SAMPLE_BITS-1] ? (~i_sample + 1'b1) : i_sample;
        sq_full   = mag * mag;
        acc_old   = r_rd_vld ? r_rd : '0;
        acc_new   = acc_old + ACC_W'(r_sq);
        fresh_q   = r_fresh[FRESH_W-1 -: ROOT_W];
        decay_q   = ROOT_W'(r_decayed[DECAY_W-1 -: LEVEL_W]);
        pick      = (fresh_q > decay_q) ? fresh_q : decay_q;
        level_new = (pick > ROOT_W'({LEVEL_W{1'b1}})) ? {LEVEL_W{1'b1}} : pick[LEVEL_W-1:0];
        out_free  = !r_ovalid || o_res.ready;
    end

    // energy memory: one read and one write port, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_wr) begin
            r_mem[i_cmd.addr] <= acc_new;
        end
        if (i_cmd.acc_rd || i_cmd.burst_rd) begin
            r_rd <= r_mem[i_cmd.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_cmd.acc_rd || i_cmd.burst_rd) begin
                r_rd_vld <= r_vld[i_cmd.addr];
            end
            if (i_cmd.clear_all) begin
                r_vld <= '0;
            end else if (i_cmd.acc_wr) begin
                r_vld[i_cmd.addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_rd) begin
            r_sq <= sq_full[SQ_W-1:0];
        end
        if (i_cmd.mul) begin
            r_fresh   <= root * i_recip;
            r_decayed <= r_level[i_cmd.addr] * i_decay;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < MAX_CHANNELS; c++) begin
                r_level[c] <= '0;
            end
        end else if (i_cmd.emit) begin
            r_level[i_cmd.addr] <= level_new;
        end
    end

    lvm_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.root_go),
        .i_radicand (RAD_W'(acc_old)),
        .o_busy     (root_busy),
        .o_root     (root)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (o_res.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_ochan  <= i_cmd.addr;
            r_olevel <= level_new;
            r_olast  <= i_cmd.last;
        end
    end

    assign o_res.valid   = r_ovalid;
    assign o_res.channel = r_ochan;
    assign o_res.level   = r_olevel;
    assign o_res.last    = r_olast;

    assign o_stat.root_busy = root_busy;
    assign o_stat.out_free  = out_free;

endmodule

// ===== sv/lvm_ctrl.sv =====
// Controller: channel and frame counters, sample accumulation and the chunk-end burst.
// Depends on lvm_pkg.
`timescale 1ns / 1ps

module lvm_ctrl import lvm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [NCH_W-1:0] i_nch,
    input  logic [NFR_W-1:0] i_nfr,
    input  t_stat            i_stat,
    output t_cmd             o_cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_ACC     = 3'd1;
    localparam logic [2:0] S_RD      = 3'd2;
    localparam logic [2:0] S_ROOT_GO = 3'd3;
    localparam logic [2:0] S_ROOT    = 3'd4;
    localparam logic [2:0] S_MUL     = 3'd5;
    localparam logic [2:0] S_EMIT    = 3'd6;

    logic [2:0]      r_state, n_state;
    logic [CH_W-1:0] r_ch, n_ch;
    logic [FR_W-1:0] r_fr, n_fr;
    logic [CH_W-1:0] r_idx, n_idx;
    logic            r_end, n_end;
    logic [CH_W-1:0] r_bc, n_bc;

    logic ch_wrap;
    logic fr_wrap;
    logic burst_last;

    always_comb begin
        ch_wrap    = (NCH_W'(r_ch) + NCH_W'(1)) >= i_nch;
        fr_wrap    = (NFR_W'(r_fr) + NFR_W'(1)) >= i_nfr;
        burst_last = (NCH_W'(r_bc) + NCH_W'(1)) >= i_nch;

        n_state = r_state;
        n_ch    = r_ch;
        n_fr    = r_fr;
        n_idx   = r_idx;
        n_end   = r_end;
        n_bc    = r_bc;
        o_ready = 1'b0;
        o_cmd   = '0;

        case (r_state)
            S_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.addr = r_ch;
                if (i_valid) begin
                    o_cmd.acc_rd = 1'b1;
                    n_idx        = r_ch;
                    n_end        = ch_wrap && fr_wrap;
                    if (ch_wrap) begin
                        n_ch = '0;
                        n_fr = fr_wrap ? '0 : r_fr + 1'b1;
                    end else begin
                        n_ch = r_ch + 1'b1;
                    end
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.acc_wr = 1'b1;
                o_cmd.addr   = r_idx;
                n_bc         = '0;
                n_state      = r_end ? S_RD : S_IDLE;
            end
            S_RD: begin
                o_cmd.burst_rd = 1'b1;
                o_cmd.addr     = r_bc;
                n_state        = S_ROOT_GO;
            end
            S_ROOT_GO: begin
                o_cmd.root_go = 1'b1;
                o_cmd.addr    = r_bc;
                n_state       = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.addr = r_bc;
                if (!i_stat.root_busy) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul  = 1'b1;
                o_cmd.addr = r_bc;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.addr = r_bc;
                o_cmd.last = burst_last;
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (burst_last) begin
                        o_cmd.clear_all = 1'b1;
                        n_state         = S_IDLE;
                    end else begin
                        n_bc    = r_bc + 1'b1;
                        n_state = S_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ch    <= '0;
            r_fr    <= '0;
            r_idx   <= '0;
            r_end   <= 1'b0;
            r_bc    <= '0;
        end else begin
            r_state <= n_state;
            r_ch    <= n_ch;
            r_fr    <= n_fr;
            r_idx   <= n_idx;
            r_end   <= n_end;
            r_bc    <= n_bc;
        end
    end

endmodule

// ===== sv/multichannel_level_meter_unit.sv =====
// Top level of the multichannel level meter: configuration registers and the
// controller/datapath pair. Depends on lvm_pkg, lvm_in_if, lvm_out_if, lvm_ctrl, lvm_dp.
`timescale 1ns / 1ps

// Interleaved signed samples arrive one per beat on i_smp; channel and frame
// counters inside the block place each one. A sample takes the beat that
// reads its channel's energy accumulator and squares the sample, then the
// cycle that writes the new sum back, after which the next beat is taken. The
// sample that closes a chunk starts a burst that reports every configured
// channel in order on o_lvl, channel 0 first, with last set on the final
// channel. Each channel goes through the memory read, the start of the square
// root unit, its steps (one result bit per cycle), a state in which the
// controller sees it finish, the scaling multiply and the level update, which
// waits while the result register is still held by o_lvl. No sample is taken
// during the burst. After the final channel every energy accumulator is
// cleared at once through per-entry valid bits, so no clearing pass is needed
// after reset either. Write configuration only while the block is idle; a
// channel count of 0 acts as 1 and above 32 as 32, chunk_frames of 0 acts as
// 1 and above 4096 as 4096.
module multichannel_level_meter_unit import lvm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    lvm_in_if.sink               i_smp,
    lvm_out_if.source            o_lvl
);

    logic [NCH_W-1:0]  r_active_chans;
    logic [NFR_W-1:0]  r_chunk_frames;
    logic [COEF_W-1:0] r_chunk_recip;
    logic [COEF_W-1:0] r_decay_coeff;

    logic [NCH_W-1:0]  nch_eff;
    logic [NFR_W-1:0]  nfr_eff;
    t_cmd              cmd;
    t_stat             stat;
    logic              ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_chans <= RST_ACTIVE_CHANS;
            r_chunk_frames <= RST_CHUNK_FRAMES;
            r_chunk_recip  <= RST_CHUNK_RECIPROCAL;
            r_decay_coeff  <= RST_DECAY_COEFF;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ACTIVE_CHANS:     r_active_chans <= i_cfg_data[NCH_W-1:0];
                CFG_CHUNK_FRAMES:     r_chunk_frames <= i_cfg_data[NFR_W-1:0];
                CFG_CHUNK_RECIPROCAL: r_chunk_recip  <= i_cfg_data[COEF_W-1:0];
                CFG_DECAY_COEFF:      r_decay_coeff  <= i_cfg_data[COEF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // clamp the counts into their usable range
    always_comb begin
        if (r_active_chans == '0) begin
            nch_eff = NCH_W'(1);
        end else if (r_active_chans > NCH_W'(MAX_CHANNELS)) begin
            nch_eff = NCH_W'(MAX_CHANNELS);
        end else begin
            nch_eff = r_active_chans;
        end

        if (r_chunk_frames == '0) begin
            nfr_eff = NFR_W'(1);
        end else if (r_chunk_frames > NFR_W'(MAX_CHUNK)) begin
            nfr_eff = NFR_W'(MAX_CHUNK);
        end else begin
            nfr_eff = r_chunk_frames;
        end
    end

    lvm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_smp.valid),
        .o_ready (ready),
        .i_nch   (nch_eff),
        .i_nfr   (nfr_eff),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    lvm_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .i_sample (i_smp.sample),
        .i_recip  (r_chunk_recip),
        .i_decay  (r_decay_coeff),
        .o_res    (o_lvl)
    );

    assign i_smp.ready = ready;

endmodule

// ===== sv/lvm_chk.sv =====
// Port-level checker for the level meter and its bind to the top level.
// Depends on lvm_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lvm_chk import lvm_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [CH_W-1:0]    i_out_channel,
    input logic [LEVEL_W-1:0] i_out_level,
    input logic               i_out_last
);

    logic [CH_W+LEVEL_W:0] payload;

    assign payload = {i_out_channel, i_out_level, i_out_last};

    // a held result keeps its payload
    `LVM_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(payload))

    // a burst still in flight blocks samples
    `LVM_ASSERT(a_burst_blocks_in, i_clk, i_rst_n, i_out_valid && !i_out_last |-> !i_in_ready)

    // every sample beat is followed by its write-back cycle
    `LVM_ASSERT(a_in_spacing, i_clk, i_rst_n, i_in_valid && i_in_ready |=> !i_in_ready)

    // reset leaves no result pending
    `LVM_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !i_out_valid)

endmodule

bind multichannel_level_meter_unit lvm_chk u_lvm_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_smp.valid),
    .i_in_ready    (i_smp.ready),
    .i_out_valid   (o_lvl.valid),
    .i_out_ready   (o_lvl.ready),
    .i_out_channel (o_lvl.channel),
    .i_out_level   (o_lvl.level),
    .i_out_last    (o_lvl.last)
);

// ===== bench/level_meter_checker.sv =====
// Checker for the multichannel level meter: predicts every level beat and compares it.
// Depends on lvm_pkg, lvm_in_if and lvm_out_if; watches the ports and drives none.
`timescale 1ns / 1ps

module level_meter_checker import lvm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    lvm_in_if                    i_smp,
    lvm_out_if                   i_lvl,
    output int                   o_fail_count,
    output int                   o_pending
);
    localparam int REPORT_CAP = 150;

    typedef struct packed {
        logic [CH_W-1:0]    channel;
        logic [LEVEL_W-1:0] level;
        logic               last;
    } t_level_beat;

    t_level_beat        level_queue[$];
    longint unsigned    energy[MAX_CHANNELS];
    logic [LEVEL_W-1:0] meter[MAX_CHANNELS];
    int unsigned        chan_pos;
    int unsigned        frame_pos;
    logic [NCH_W-1:0]   active_chans;
    logic [NFR_W-1:0]   chunk_frames;
    logic [COEF_W-1:0]  chunk_recip;
    logic [COEF_W-1:0]  decay_coeff;
    int                 reports;

    // Add one sample's square to its channel; at chunk end queue one level per channel.
    function automatic void absorb_sample(input logic signed [SAMPLE_BITS-1:0] s);
        int unsigned     nch;
        int unsigned     nfr;
        int              sv;
        longint unsigned mag;
        longint unsigned root;
        longint unsigned trial;
        longint unsigned fresh;
        longint unsigned decayed;
        longint unsigned lvl;
        t_level_beat     beat;
        nch = (active_chans == 0) ? 1 :
              (active_chans > MAX_CHANNELS) ? MAX_CHANNELS : active_chans;
        nfr = (chunk_frames == 0) ? 1 :
              (chunk_frames > MAX_CHUNK) ? MAX_CHUNK : chunk_frames;
        sv  = s;
        mag = (sv < 0) ? -sv : sv;
        energy[chan_pos % MAX_CHANNELS] += mag * mag;

        if (chan_pos + 1 >= nch) begin
            chan_pos = 0;
            if (frame_pos + 1 < nfr) begin
                frame_pos++;
                return;
            end
            frame_pos = 0;
        end else begin
            chan_pos++;
            return;
        end

        for (int c = 0; c < nch; c++) begin
            // floor square root, one bit at a time from the top
            root = 0;
            for (int b = ROOT_W - 1; b >= 0; b--) begin
                trial = root | (64'd1 << b);
                if (trial * trial <= energy[c])
                    root = trial;
            end
            fresh   = (root * 64'(chunk_recip)) >> 16;
            decayed = (64'(meter[c]) * 64'(decay_coeff)) >> 16;
            lvl     = (fresh > decayed) ? fresh : decayed;
            if (lvl > 64'({LEVEL_W{1'b1}}))
                lvl = 64'({LEVEL_W{1'b1}});
            meter[c]     = lvl[LEVEL_W-1:0];
            beat.channel = CH_W'(c);
            beat.level   = meter[c];
            beat.last    = (c == nch - 1);
            level_queue.push_back(beat);
        end
        foreach (energy[k])
            energy[k] = 0;
    endfunction

    task automatic flag(input string field, input longint want_v, input longint got_v);
        o_fail_count++;
        if (reports < REPORT_CAP)
            $display("%0t: %s expected %0d, got %0d", $time, field, want_v, got_v);
        reports++;
    endtask

    always @(posedge i_clk) begin
        t_level_beat want;
        if (!i_rst_n) begin
            level_queue.delete();
            foreach (energy[k]) begin
                energy[k] = 0;
                meter[k]  = '0;
            end
            chan_pos     = 0;
            frame_pos    = 0;
            active_chans = RST_ACTIVE_CHANS;
            chunk_frames = RST_CHUNK_FRAMES;
            chunk_recip  = RST_CHUNK_RECIPROCAL;
            decay_coeff  = RST_DECAY_COEFF;
            o_fail_count = 0;
            reports      = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ACTIVE_CHANS:     active_chans = i_cfg_data[NCH_W-1:0];
                    CFG_CHUNK_FRAMES:     chunk_frames = i_cfg_data[NFR_W-1:0];
                    CFG_CHUNK_RECIPROCAL: chunk_recip  = i_cfg_data[COEF_W-1:0];
                    CFG_DECAY_COEFF:      decay_coeff  = i_cfg_data[COEF_W-1:0];
                    default: ;
                endcase
            end
            if (i_smp.valid && i_smp.ready)
                absorb_sample(i_smp.sample);
            if (i_lvl.valid && i_lvl.ready) begin
                if (level_queue.size() == 0) begin
                    flag("unexpected level beat, channel", -1, i_lvl.channel);
                end else begin
                    want = level_queue.pop_front();
                    if (i_lvl.channel !== want.channel)
                        flag("channel", want.channel, i_lvl.channel);
                    if (i_lvl.level !== want.level)
                        flag("level", want.level, i_lvl.level);
                    if (i_lvl.last !== want.last)
                        flag("last", want.last, i_lvl.last);
                end
            end
        end
        o_pending = level_queue.size();
    end
endmodule

// ===== bench/testbench.sv =====
// Top of the level meter bench: clock, reset, sample and level traffic, verdict.
// Depends on lvm_pkg, lvm_in_if, lvm_out_if, multichannel_level_meter_unit and
// level_meter_checker.
`timescale 1ns / 1ps

module testbench;
    import lvm_pkg::*;

    localparam int          RANDOM_ITEMS = 300;
    localparam int          PHASE_CAP    = 48;     // most samples in one random phase
    localparam int          BURST_PAD    = 40;     // covers a sample's write-back and a burst tail
    localparam int          SQUEEZE_LEN  = 800;    // cycles the level sink holds off once
    localparam int unsigned CYCLE_LIMIT  = 2000000;
    localparam logic [3:0]  ALL_REGS     = 4'b1111;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;
    int                   fail_count;
    int                   pending;
    bit                   quiet;        // no idling on either side while set
    bit                   squeeze_req;  // asks the level sink for its long hold-off
    int unsigned          cycles = 0;

    lvm_in_if  smp_if ();
    lvm_out_if lvl_if ();

    multichannel_level_meter_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_smp      (smp_if),
        .o_lvl      (lvl_if)
    );

    level_meter_checker level_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_smp        (smp_if),
        .i_lvl        (lvl_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake or a lost level beat ends up here.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Level sink: drop ready about one cycle in ten, never while quiet, and once
    // hold it low for a long stretch so that a burst backs up into the sample side.
    initial begin
        int hold_left;
        bit squeezed;
        hold_left     = 0;
        squeezed      = 1'b0;
        lvl_if.ready  = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left != 0) begin
                lvl_if.ready <= 1'b0;
                hold_left--;
            end else if (squeeze_req && !squeezed) begin
                squeezed     = 1'b1;
                hold_left    = SQUEEZE_LEN - 1;
                lvl_if.ready <= 1'b0;
            end else begin
                lvl_if.ready <= quiet || ($urandom_range(0, 99) >= 10);
            end
        end
    end

    // Offer one sample and hold it until taken; returns at the falling edge after
    // the beat with valid still high, so a following sample goes straight out.
    task automatic offer(input logic signed [SAMPLE_BITS-1:0] s);
        while (!quiet && $urandom_range(0, 99) < 10) begin
            smp_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        smp_if.valid  <= 1'b1;
        smp_if.sample <= s;
        do
            @(posedge i_clk);
        while (!smp_if.ready);
        @(negedge i_clk);
    endtask

    // Drop valid, wait for every predicted level, then give the block time to
    // finish a sample write-back that produces no level.
    task automatic settle();
        smp_if.valid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (BURST_PAD) @(negedge i_clk);
    endtask

    // Write the registers picked by mask, one per cycle; only call when settled.
    task automatic write_regs(input logic [3:0] mask, input int unsigned nch,
                              input int unsigned nfr, input int unsigned recip,
                              input int unsigned decay);
        logic [CFG_IDX_W-1:0] codes[4];
        logic [CFG_W-1:0]     vals[4];
        codes = '{CFG_ACTIVE_CHANS, CFG_CHUNK_FRAMES, CFG_CHUNK_RECIPROCAL, CFG_DECAY_COEFF};
        vals  = '{CFG_W'(nch), CFG_W'(nfr), CFG_W'(recip), CFG_W'(decay)};
        for (int i = 0; i < 4; i++) begin
            if (mask[codes[i]]) begin
                cfg_we   <= 1'b1;
                cfg_idx  <= codes[i];
                cfg_data <= vals[i];
                @(negedge i_clk);
            end
        end
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin
        int unsigned                   sent;
        int unsigned                   items;
        int unsigned                   nch;
        int unsigned                   nfr;
        int unsigned                   n_eff;
        int unsigned                   f_eff;
        int unsigned                   recip;
        int unsigned                   decay;
        int                            phase;
        logic signed [SAMPLE_BITS-1:0] s;

        cfg_we        = 1'b0;
        cfg_idx       = CFG_ACTIVE_CHANS;
        cfg_data      = '0;
        smp_if.valid  = 1'b0;
        smp_if.sample = '0;
        quiet         = 1'b0;
        squeeze_req   = 1'b0;
        i_rst_n       = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: one channel, long chunk. Fill part of a chunk with the
        // sample extremes, then shrink the chunk so the next sample closes it and
        // the reset reciprocal and decay show in the level.
        offer(16'sh7FFF);
        offer(16'sh8000);
        offer(16'sh0000);
        offer(16'shFFFF);
        offer(16'sh0001);
        settle();
        write_regs(4'(1 << CFG_CHUNK_FRAMES), 0, 1, 0, 0);
        offer(16'sh5555);
        offer(16'sh8000);
        settle();

        // Zero channels and a zero chunk both act as one; full-scale decay holds
        // the level when the fresh value drops to nothing.
        write_regs(ALL_REGS, 0, 0, 16'hFFFF, 16'hFFFF);
        offer(16'sh8000);
        offer(16'sh0000);
        settle();

        // Oversized chunk, then shrink it: six full-scale squares push the root
        // past the level range, so the level must saturate.
        write_regs(ALL_REGS, 63 - 62, 8191, 16'hFFFF, 0);
        repeat (6) offer(16'sh8000);
        settle();
        write_regs(4'(1 << CFG_CHUNK_FRAMES), 0, 1, 0, 0);
        offer(16'sh7FFF);
        settle();

        // Stale channels: leave energy in channels 1 and 2, shrink to one channel
        // so only channel 0 reports, then widen again and expect clean sums.
        write_regs(ALL_REGS, 3, MAX_CHUNK, 4000, 30000);
        offer(16'sd1000);
        offer(-16'sd2000);
        settle();
        write_regs(4'((1 << CFG_ACTIVE_CHANS) | (1 << CFG_CHUNK_FRAMES)), 1, 1, 0, 0);
        offer(16'sd3000);
        settle();
        write_regs(4'(1 << CFG_ACTIVE_CHANS), 3, 0, 0, 0);
        offer(16'sd5);
        offer(16'sd6);
        offer(16'sd7);
        settle();

        // Random phases: each one programs a fresh setting and streams whole
        // chunks with random content, sometimes with a partial chunk left over.
        // No phase runs more than PHASE_CAP samples, so at least seven phases run.
        // The first phase runs the widest frame, the third one carries the long
        // hold-off on the level side, and phases five to seven run full length
        // with no idling.
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            quiet = (phase >= 4 && phase < 7);
            if (phase == 0) begin
                nch = 63;
            end else begin
                case ($urandom_range(0, 9))
                    0:       nch = 0;
                    1:       nch = MAX_CHANNELS;
                    2:       nch = $urandom_range(MAX_CHANNELS + 1, 63);
                    default: nch = $urandom_range(1, 6);
                endcase
            end
            if (phase == 2)
                nch = 16;
            n_eff = (nch == 0) ? 1 : (nch > MAX_CHANNELS) ? MAX_CHANNELS : nch;

            // keep chunks short, or bursts come too seldom to matter
            if (n_eff >= 16) begin
                nfr = $urandom_range(1, 2);
            end else begin
                case ($urandom_range(0, 11))
                    0:       nfr = 0;
                    1:       nfr = $urandom_range(MAX_CHUNK + 1, 8191);
                    default: nfr = $urandom_range(1, 8);
                endcase
            end
            if (phase == 0)
                nfr = 1;
            f_eff = (nfr == 0) ? 1 : (nfr > MAX_CHUNK) ? MAX_CHUNK : nfr;

            case ($urandom_range(0, 5))
                0:       recip = 0;
                1:       recip = 16'hFFFF;
                2, 3:    recip = (f_eff == 1) ? 16'hFFFF : 65536 / f_eff;
                default: recip = $urandom_range(0, 16'hFFFF);
            endcase
            case ($urandom_range(0, 4))
                0:       decay = 0;
                1:       decay = 16'hFFFF;
                default: decay = $urandom_range(0, 16'hFFFF);
            endcase
            write_regs(ALL_REGS, nch, nfr, recip, decay);

            if (f_eff > 8)
                items = $urandom_range(5, 40);
            else
                items = n_eff * f_eff * $urandom_range(1, 3) +
                        (($urandom_range(0, 3) == 0) ? $urandom_range(1, n_eff) : 0);
            if (quiet || items > PHASE_CAP)
                items = PHASE_CAP;

            if (phase == 2)
                squeeze_req = 1'b1;

            repeat (items) begin
                case ($urandom_range(0, 9))
                    0: s = 16'sh8000;
                    1: s = 16'sh7FFF;
                    2: begin
                        s = SAMPLE_BITS'($urandom_range(0, 15));
                        if ($urandom_range(0, 1) == 1)
                            s = -s;
                    end
                    default: s = SAMPLE_BITS'($urandom);
                endcase
                offer(s);
            end
            sent += items;
            settle();
            phase++;
        end

        // settle() has already drained every predicted level and waited out the tail
        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
